// ----- design/lsf_pkg.sv -----
// Shared types for the link session controller: session states, event codes
// and error codes. No dependencies.
package lsf_pkg;

  // Session states
  typedef enum logic [3:0] {
    ST_IDLE         = 4'd0,
    ST_SCANNING     = 4'd1,
    ST_CONNECTING   = 4'd2,
    ST_WAIT_SVC     = 4'd3,
    ST_BINDING      = 4'd4,
    ST_CREATE_PORT  = 4'd5,
    ST_ENABLE_NTF   = 4'd6,
    ST_STREAMING    = 4'd7,
    ST_RECONNECTING = 4'd8,
    ST_ERROR        = 4'd9
  } state_t;

  // Event codes carried by one request
  typedef enum logic [4:0] {
    EV_SCAN           = 5'd0,
    EV_CONNECT        = 5'd1,
    EV_DISCONNECT     = 5'd2,
    EV_FORGET         = 5'd3,
    EV_DEVICE_FOUND   = 5'd4,
    EV_CONNECTED      = 5'd5,
    EV_DISCONNECTED   = 5'd6,
    EV_SVC_RESOLVED   = 5'd7,
    EV_ADAPTER_OFF    = 5'd8,
    EV_CONNECT_FAILED = 5'd9,
    EV_SVC_NOT_FOUND  = 5'd10,
    EV_CHAR_FOUND     = 5'd11,
    EV_CHAR_NOT_FOUND = 5'd12,
    EV_PORT_READY     = 5'd13,
    EV_PORT_FAILED    = 5'd14,
    EV_PORT_IO_FAILED = 5'd15,
    EV_PORT_DEC_FAIL  = 5'd16,
    EV_NOTIFY_OK      = 5'd17,
    EV_NOTIFY_FAILED  = 5'd18,
    EV_WRITE_FAILED   = 5'd19,
    EV_RUNTIME_FAILED = 5'd20,
    EV_RECONN_TIMER   = 5'd21,
    EV_TIMEOUT        = 5'd22,
    EV_FATAL          = 5'd23
  } event_t;

  // Error codes
  typedef enum logic [4:0] {
    ER_NONE        = 5'd0,
    ER_UNAVAILABLE = 5'd1,
    ER_ADAPTER_OFF = 5'd2,
    ER_CONN_FAILED = 5'd3,
    ER_CONN_TMO    = 5'd4,
    ER_SVC_TMO     = 5'd5,
    ER_SVC_NF      = 5'd6,
    ER_CHAR_NF     = 5'd7,
    ER_NTF_FAILED  = 5'd8,
    ER_NTF_TMO     = 5'd9,
    ER_WR_FAILED   = 5'd10,
    ER_PORT_FAILED = 5'd11,
    ER_PORT_IO     = 5'd12,
    ER_PORT_DEC    = 5'd13,
    ER_RUNTIME     = 5'd14,
    ER_DISCONN     = 5'd15,
    ER_INVALID     = 5'd16,
    ER_INTERNAL    = 5'd17
  } err_t;

  // Configuration register indexes
  localparam logic REG_RECONNECT_EN = 1'b0;

endpackage

// ----- design/link_session_fsm.sv -----
// Link session controller top level: event input register, next-state logic
// and result register, plus the configuration port. Uses lsf_pkg.
//
//  channel   | direction | signals                              | width
//  ----------+-----------+--------------------------------------+--------------
//  event     | in        | ev_valid, ev_stall, event_code       | 5
//  result    | out       | res_valid, res_stall, accepted,      | 1,4,5,1,16
//            |           | session_state, error_code,           |
//            |           | streaming_ready, attempt_count       |
//  config    | in/out    | psel, penable, pwrite, paddr, pwdata,| 3 addr, 32 data
//            |           | prdata, pready                       |
//
// A taken event goes from the event input register through the next-state logic
// into the result register; one event is taken every cycle while ev_stall is low.
// Synchronous reset returns the session to idle with all flags, the error
// and the attempt counter cleared, and reconnect_en set.
// A stalled result holds; the event register keeps taking requests until it
// too is full, then ev_stall rises.
module link_session_fsm (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // event channel
  input  logic        ev_valid,
  output logic        ev_stall,
  input  logic [4:0]  event_code,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic        accepted,
  output logic [3:0]  session_state,
  output logic [4:0]  error_code,
  output logic        streaming_ready,
  output logic [15:0] attempt_count
);

  // Configuration register
  logic reconnect_en;

  // Session registers
  lsf_pkg::state_t state, state_next;
  lsf_pkg::err_t   last_error, last_error_next;
  logic            link_up, link_up_next;
  logic            services_done, services_done_next;
  logic            notify_on, notify_on_next;
  logic            port_ready, port_ready_next;
  logic [15:0]     attempts, attempts_next;

  // Event input register
  logic            ev_q_valid;
  lsf_pkg::event_t ev_q;

  // Handshake and decode controls
  logic            res_free;
  logic            ev_move;
  logic            ok;
  logic            td;
  logic            td_keep;
  logic            rec;
  lsf_pkg::err_t   rec_err;
  logic            ready_next;
  logic            cfg_wr;

  // Configuration port: always ready, one register at the bottom word
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reconnect_en <= 1'b1;
    end else if (cfg_wr && (paddr[2] == lsf_pkg::REG_RECONNECT_EN)) begin
      reconnect_en <= pwdata[0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == lsf_pkg::REG_RECONNECT_EN) begin
      prdata = {31'd0, reconnect_en};
    end
  end

  // Pipeline handshake: the event register advances when the result slot frees
  assign res_free = !res_valid || !res_stall;
  assign ev_move  = ev_q_valid && res_free;
  assign ev_stall = ev_q_valid && !res_free;

  // Capture an event request
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_q_valid <= 1'b0;
    end else if (!ev_stall) begin
      ev_q_valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!ev_stall && ev_valid) begin
      ev_q <= lsf_pkg::event_t'(event_code);
    end
  end

  // Next-state logic: global events first, then per-state transitions
  always_comb begin
    state_next         = state;
    last_error_next    = last_error;
    link_up_next       = link_up;
    services_done_next = services_done;
    notify_on_next     = notify_on;
    port_ready_next    = port_ready;
    attempts_next      = attempts;
    ok                 = 1'b1;
    td                 = 1'b0;
    td_keep            = 1'b0;
    rec                = 1'b0;
    rec_err            = lsf_pkg::ER_NONE;

    unique case (ev_q) inside
      lsf_pkg::EV_DISCONNECT, lsf_pkg::EV_FORGET: begin
        td              = 1'b1;
        state_next      = lsf_pkg::ST_IDLE;
        last_error_next = lsf_pkg::ER_NONE;
      end
      lsf_pkg::EV_FATAL: begin
        state_next      = lsf_pkg::ST_ERROR;
        last_error_next = lsf_pkg::ER_INTERNAL;
      end
      lsf_pkg::EV_RUNTIME_FAILED: begin
        state_next      = lsf_pkg::ST_ERROR;
        last_error_next = lsf_pkg::ER_RUNTIME;
      end
      lsf_pkg::EV_ADAPTER_OFF: begin
        td              = 1'b1;
        state_next      = lsf_pkg::ST_ERROR;
        last_error_next = lsf_pkg::ER_ADAPTER_OFF;
      end
      lsf_pkg::EV_CONNECT_FAILED: begin
        if (state == lsf_pkg::ST_CONNECTING) begin
          td      = 1'b1;
          rec     = 1'b1;
          rec_err = lsf_pkg::ER_CONN_FAILED;
        end else begin
          state_next      = lsf_pkg::ST_ERROR;
          last_error_next = lsf_pkg::ER_CONN_FAILED;
        end
      end
      lsf_pkg::EV_TIMEOUT: begin
        if (state == lsf_pkg::ST_CONNECTING) begin
          td      = 1'b1;
          rec     = 1'b1;
          rec_err = lsf_pkg::ER_CONN_TMO;
        end else if (state == lsf_pkg::ST_WAIT_SVC) begin
          td      = 1'b1;
          td_keep = 1'b1;
          rec     = 1'b1;
          rec_err = lsf_pkg::ER_SVC_TMO;
        end else if (state == lsf_pkg::ST_ENABLE_NTF) begin
          td      = 1'b1;
          td_keep = 1'b1;
          rec     = 1'b1;
          rec_err = lsf_pkg::ER_NTF_TMO;
        end else begin
          state_next      = lsf_pkg::ST_ERROR;
          last_error_next = lsf_pkg::ER_INTERNAL;
        end
      end
      lsf_pkg::EV_SVC_NOT_FOUND: begin
        state_next      = lsf_pkg::ST_ERROR;
        last_error_next = lsf_pkg::ER_SVC_NF;
      end
      lsf_pkg::EV_CHAR_NOT_FOUND: begin
        state_next      = lsf_pkg::ST_ERROR;
        last_error_next = lsf_pkg::ER_CHAR_NF;
      end
      lsf_pkg::EV_PORT_FAILED: begin
        state_next      = lsf_pkg::ST_ERROR;
        last_error_next = lsf_pkg::ER_PORT_FAILED;
      end
      lsf_pkg::EV_NOTIFY_FAILED: begin
        td      = 1'b1;
        td_keep = 1'b1;
        rec     = 1'b1;
        rec_err = lsf_pkg::ER_NTF_FAILED;
      end
      lsf_pkg::EV_WRITE_FAILED: begin
        td      = 1'b1;
        td_keep = 1'b1;
        rec     = 1'b1;
        rec_err = lsf_pkg::ER_WR_FAILED;
      end
      lsf_pkg::EV_PORT_IO_FAILED: begin
        last_error_next = lsf_pkg::ER_PORT_IO;
        if (state != lsf_pkg::ST_STREAMING) begin
          state_next = lsf_pkg::ST_ERROR;
        end
      end
      lsf_pkg::EV_PORT_DEC_FAIL: begin
        last_error_next = lsf_pkg::ER_PORT_DEC;
        if (state != lsf_pkg::ST_STREAMING) begin
          state_next = lsf_pkg::ST_ERROR;
        end
      end
      default: begin
        // Per-state transitions; anything unmatched is an invalid transition
        ok = 1'b0;
        unique case (state)
          lsf_pkg::ST_IDLE: begin
            if (ev_q == lsf_pkg::EV_SCAN) begin
              ok = 1'b1;
              state_next = lsf_pkg::ST_SCANNING;
            end else if (ev_q == lsf_pkg::EV_CONNECT) begin
              ok = 1'b1;
              state_next = lsf_pkg::ST_CONNECTING;
            end
          end
          lsf_pkg::ST_SCANNING: begin
            if (ev_q == lsf_pkg::EV_DEVICE_FOUND) begin
              ok = 1'b1;
            end else if (ev_q == lsf_pkg::EV_CONNECT) begin
              ok = 1'b1;
              state_next = lsf_pkg::ST_CONNECTING;
            end
          end
          lsf_pkg::ST_CONNECTING: begin
            if (ev_q == lsf_pkg::EV_CONNECTED) begin
              ok = 1'b1;
              link_up_next = 1'b1;
              state_next   = lsf_pkg::ST_WAIT_SVC;
            end else if (ev_q == lsf_pkg::EV_DISCONNECTED) begin
              ok      = 1'b1;
              td      = 1'b1;
              rec     = 1'b1;
              rec_err = lsf_pkg::ER_CONN_FAILED;
            end
          end
          lsf_pkg::ST_WAIT_SVC: begin
            if (ev_q == lsf_pkg::EV_SVC_RESOLVED) begin
              ok = 1'b1;
              services_done_next = 1'b1;
              state_next         = lsf_pkg::ST_BINDING;
            end
          end
          lsf_pkg::ST_BINDING: begin
            if (ev_q == lsf_pkg::EV_CHAR_FOUND) begin
              ok = 1'b1;
              state_next = lsf_pkg::ST_CREATE_PORT;
            end
          end
          lsf_pkg::ST_CREATE_PORT: begin
            if (ev_q == lsf_pkg::EV_PORT_READY) begin
              ok = 1'b1;
              port_ready_next = 1'b1;
              state_next      = lsf_pkg::ST_ENABLE_NTF;
            end
          end
          lsf_pkg::ST_ENABLE_NTF: begin
            if (ev_q == lsf_pkg::EV_NOTIFY_OK) begin
              ok = 1'b1;
              notify_on_next = 1'b1;
              state_next     = lsf_pkg::ST_STREAMING;
            end
          end
          lsf_pkg::ST_STREAMING: begin
          end
          lsf_pkg::ST_RECONNECTING: begin
            if ((ev_q == lsf_pkg::EV_RECONN_TIMER) || (ev_q == lsf_pkg::EV_CONNECT)) begin
              ok = 1'b1;
              attempts_next = attempts + 16'd1;
              state_next    = lsf_pkg::ST_CONNECTING;
            end
          end
          lsf_pkg::ST_ERROR: begin
            if (ev_q == lsf_pkg::EV_CONNECT) begin
              ok = 1'b1;
              td = 1'b1;
              state_next = lsf_pkg::ST_CONNECTING;
            end else if (ev_q == lsf_pkg::EV_SCAN) begin
              ok = 1'b1;
              td = 1'b1;
              state_next = lsf_pkg::ST_SCANNING;
            end
          end
          default: begin
          end
        endcase

        // Lost link in any state from service wait through streaming keeps the port
        if (!ok && (ev_q == lsf_pkg::EV_DISCONNECTED) &&
            (state == lsf_pkg::ST_WAIT_SVC || state == lsf_pkg::ST_BINDING ||
             state == lsf_pkg::ST_CREATE_PORT || state == lsf_pkg::ST_ENABLE_NTF ||
             state == lsf_pkg::ST_STREAMING)) begin
          ok      = 1'b1;
          td      = 1'b1;
          td_keep = 1'b1;
          rec     = 1'b1;
          rec_err = lsf_pkg::ER_DISCONN;
        end

        // Mark an unmatched event invalid; clear the error on a state change; a found device keeps it
        if (!ok) begin
          last_error_next = lsf_pkg::ER_INVALID;
        end else if (state_next != state) begin
          last_error_next = lsf_pkg::ER_NONE;
        end
      end
    endcase

    // Drop link, services and notify; drop the port unless kept
    if (td) begin
      link_up_next       = 1'b0;
      services_done_next = 1'b0;
      notify_on_next     = 1'b0;
      if (!td_keep) begin
        port_ready_next = 1'b0;
      end
    end

    // Recoverable failure: reconnect or stop in error
    if (rec) begin
      state_next      = reconnect_en ? lsf_pkg::ST_RECONNECTING : lsf_pkg::ST_ERROR;
      last_error_next = rec_err;
    end

    ready_next = (state_next == lsf_pkg::ST_STREAMING) && link_up_next &&
                 services_done_next && notify_on_next && port_ready_next;
  end

  // Session state registers: advance on each processed event
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lsf_pkg::ST_IDLE;
      last_error    <= lsf_pkg::ER_NONE;
      link_up       <= 1'b0;
      services_done <= 1'b0;
      notify_on     <= 1'b0;
      port_ready    <= 1'b0;
      attempts      <= 16'd0;
    end else if (ev_move) begin
      state         <= state_next;
      last_error    <= last_error_next;
      link_up       <= link_up_next;
      services_done <= services_done_next;
      notify_on     <= notify_on_next;
      port_ready    <= port_ready_next;
      attempts      <= attempts_next;
    end
  end

  // Result register: load on move, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= ev_move;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_move) begin
      accepted        <= ok;
      session_state   <= state_next;
      error_code      <= last_error_next;
      streaming_ready <= ready_next;
      attempt_count   <= attempts_next;
    end
  end

  // Event register only stalls while it holds a request
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    ev_stall |-> ev_q_valid)
    else $error("event stall without a held request");

  // Error state always carries an error code
  a_error_has_code: assert property (@(posedge clk) disable iff (rst)
    (state == lsf_pkg::ST_ERROR) |-> (last_error != lsf_pkg::ER_NONE))
    else $error("error state with no error code");

  // Attempt counter moves only on reconnecting to connecting
  a_attempt_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (attempts != $past(attempts))) |->
      (($past(state) == lsf_pkg::ST_RECONNECTING) &&
       (state == lsf_pkg::ST_CONNECTING) && (attempts == $past(attempts) + 16'd1)))
    else $error("attempt counter changed outside a reconnect");

  // Streaming readiness is only reported in the streaming state
  a_ready_streaming: assert property (@(posedge clk) disable iff (rst)
    (res_valid && streaming_ready) |->
      (session_state == lsf_pkg::ST_STREAMING))
    else $error("streaming_ready outside streaming state");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for link_session_fsm: directed event table, then
// random event streams under both reconnect settings.
// Depends on lsf_pkg and link_session_fsm only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int ITEMS_PER_PHASE = 150;
  localparam logic [4:0] EV_BAD_HIGH = 5'd31;
  localparam logic [2:0] AUTO_RC_ADDR = 3'(4 * lsf_pkg::REG_RECONNECT_EN);
  localparam logic PHASE_AUTO [4] = '{1'b0, 1'b1, 1'b0, 1'b1};

  typedef struct packed {
    logic            accepted;
    lsf_pkg::state_t session_state;
    lsf_pkg::err_t   error_code;
    logic            streaming_ready;
    logic [15:0]     attempt_count;
  } session_rsp_t;

  typedef struct packed {
    logic [4:0]     code;
    logic           typed;
    session_rsp_t   rsp;
  } dir_row_t;

  // Directed walk: full bring-up, streaming faults, reconnect, error recovery.
  // Rows with typed=0 take their expectation from the predictor.
  localparam dir_row_t DIR_ROWS [27] = '{
    '{lsf_pkg::EV_SCAN, 1'b1,
      '{1'b1, lsf_pkg::ST_SCANNING, lsf_pkg::ER_NONE, 1'b0, 16'd0}},
    '{lsf_pkg::EV_DEVICE_FOUND, 1'b1,
      '{1'b1, lsf_pkg::ST_SCANNING, lsf_pkg::ER_NONE, 1'b0, 16'd0}},
    '{lsf_pkg::EV_CONNECT, 1'b1,
      '{1'b1, lsf_pkg::ST_CONNECTING, lsf_pkg::ER_NONE, 1'b0, 16'd0}},
    '{lsf_pkg::EV_CONNECTED, 1'b1,
      '{1'b1, lsf_pkg::ST_WAIT_SVC, lsf_pkg::ER_NONE, 1'b0, 16'd0}},
    '{lsf_pkg::EV_SVC_RESOLVED, 1'b1,
      '{1'b1, lsf_pkg::ST_BINDING, lsf_pkg::ER_NONE, 1'b0, 16'd0}},
    '{lsf_pkg::EV_CHAR_FOUND, 1'b1,
      '{1'b1, lsf_pkg::ST_CREATE_PORT, lsf_pkg::ER_NONE, 1'b0, 16'd0}},
    '{lsf_pkg::EV_PORT_READY, 1'b1,
      '{1'b1, lsf_pkg::ST_ENABLE_NTF, lsf_pkg::ER_NONE, 1'b0, 16'd0}},
    '{lsf_pkg::EV_NOTIFY_OK, 1'b1,
      '{1'b1, lsf_pkg::ST_STREAMING, lsf_pkg::ER_NONE, 1'b1, 16'd0}},
    '{lsf_pkg::EV_PORT_IO_FAILED, 1'b0, '0},
    '{lsf_pkg::EV_PORT_DEC_FAIL,  1'b0, '0},
    '{lsf_pkg::EV_DISCONNECTED,   1'b0, '0},
    '{lsf_pkg::EV_RECONN_TIMER,   1'b0, '0},
    '{lsf_pkg::EV_TIMEOUT,        1'b0, '0},
    '{EV_BAD_HIGH, 1'b1,
      '{1'b0, lsf_pkg::ST_RECONNECTING, lsf_pkg::ER_INVALID, 1'b0, 16'd1}},
    '{lsf_pkg::EV_CONNECT,        1'b0, '0},
    '{lsf_pkg::EV_CONNECT_FAILED, 1'b0, '0},
    '{lsf_pkg::EV_ADAPTER_OFF, 1'b1,
      '{1'b1, lsf_pkg::ST_ERROR, lsf_pkg::ER_ADAPTER_OFF, 1'b0, 16'd2}},
    '{lsf_pkg::EV_SCAN,           1'b0, '0},
    '{lsf_pkg::EV_FATAL, 1'b1,
      '{1'b1, lsf_pkg::ST_ERROR, lsf_pkg::ER_INTERNAL, 1'b0, 16'd2}},
    '{lsf_pkg::EV_RUNTIME_FAILED, 1'b1,
      '{1'b1, lsf_pkg::ST_ERROR, lsf_pkg::ER_RUNTIME, 1'b0, 16'd2}},
    '{lsf_pkg::EV_SVC_NOT_FOUND, 1'b1,
      '{1'b1, lsf_pkg::ST_ERROR, lsf_pkg::ER_SVC_NF, 1'b0, 16'd2}},
    '{lsf_pkg::EV_CHAR_NOT_FOUND, 1'b1,
      '{1'b1, lsf_pkg::ST_ERROR, lsf_pkg::ER_CHAR_NF, 1'b0, 16'd2}},
    '{lsf_pkg::EV_PORT_FAILED, 1'b1,
      '{1'b1, lsf_pkg::ST_ERROR, lsf_pkg::ER_PORT_FAILED, 1'b0, 16'd2}},
    '{lsf_pkg::EV_NOTIFY_FAILED,  1'b0, '0},
    '{lsf_pkg::EV_WRITE_FAILED,   1'b0, '0},
    '{lsf_pkg::EV_DISCONNECT, 1'b1,
      '{1'b1, lsf_pkg::ST_IDLE, lsf_pkg::ER_NONE, 1'b0, 16'd2}},
    '{lsf_pkg::EV_FORGET, 1'b1,
      '{1'b1, lsf_pkg::ST_IDLE, lsf_pkg::ER_NONE, 1'b0, 16'd2}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        ev_valid = 1'b0;
  logic        ev_stall;
  logic [4:0]  event_code = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        accepted;
  logic [3:0]  session_state;
  logic [4:0]  error_code;
  logic        streaming_ready;
  logic [15:0] attempt_count;

  // Predicted session: state, flags, counter and register copy
  lsf_pkg::state_t sess_st = lsf_pkg::ST_IDLE;
  lsf_pkg::err_t   last_err = lsf_pkg::ER_NONE;
  logic            link_up = 1'b0;
  logic            svc_done = 1'b0;
  logic            ntf_on = 1'b0;
  logic            port_rdy = 1'b0;
  logic [15:0]     attempts = '0;
  logic            auto_rc = 1'b1;

  session_rsp_t pending_results [$];
  int           fail_count = 0;
  int           quiet_cycles = 0;
  logic         calm = 1'b0;

  link_session_fsm DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .ev_valid(ev_valid), .ev_stall(ev_stall), .event_code(event_code),
    .res_valid(res_valid), .res_stall(res_stall),
    .accepted(accepted), .session_state(session_state), .error_code(error_code),
    .streaming_ready(streaming_ready), .attempt_count(attempt_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void report_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // Drop the link flags; keep the port only where the teardown allows it
  function automatic void drop_link(input logic keep_port);
    link_up = 1'b0;
    svc_done = 1'b0;
    ntf_on = 1'b0;
    if (!keep_port) port_rdy = 1'b0;
  endfunction

  function automatic void enter_error(input lsf_pkg::err_t err);
    sess_st = lsf_pkg::ST_ERROR;
    last_err = err;
  endfunction

  function automatic void enter_state(input lsf_pkg::state_t st);
    sess_st = st;
    last_err = lsf_pkg::ER_NONE;
  endfunction

  function automatic void recover(input lsf_pkg::err_t err, input logic keep_port);
    drop_link(keep_port);
    if (auto_rc) begin
      sess_st = lsf_pkg::ST_RECONNECTING;
      last_err = err;
    end else begin
      enter_error(err);
    end
  endfunction

  // Advance the predicted session by one event and return the expected result
  function automatic session_rsp_t predict_session(input logic [4:0] code);
    session_rsp_t rsp;
    logic ok;
    logic global_hit;
    ok = 1'b1;
    global_hit = 1'b1;
    case (code)
      lsf_pkg::EV_DISCONNECT, lsf_pkg::EV_FORGET: begin
        drop_link(1'b0);
        enter_state(lsf_pkg::ST_IDLE);
      end
      lsf_pkg::EV_FATAL:          enter_error(lsf_pkg::ER_INTERNAL);
      lsf_pkg::EV_RUNTIME_FAILED: enter_error(lsf_pkg::ER_RUNTIME);
      lsf_pkg::EV_ADAPTER_OFF: begin
        drop_link(1'b0);
        enter_error(lsf_pkg::ER_ADAPTER_OFF);
      end
      lsf_pkg::EV_CONNECT_FAILED: begin
        if (sess_st == lsf_pkg::ST_CONNECTING) recover(lsf_pkg::ER_CONN_FAILED, 1'b0);
        else enter_error(lsf_pkg::ER_CONN_FAILED);
      end
      lsf_pkg::EV_TIMEOUT: begin
        case (sess_st)
          lsf_pkg::ST_CONNECTING: recover(lsf_pkg::ER_CONN_TMO, 1'b0);
          lsf_pkg::ST_WAIT_SVC:   recover(lsf_pkg::ER_SVC_TMO, 1'b1);
          lsf_pkg::ST_ENABLE_NTF: recover(lsf_pkg::ER_NTF_TMO, 1'b1);
          default:                enter_error(lsf_pkg::ER_INTERNAL);
        endcase
      end
      lsf_pkg::EV_SVC_NOT_FOUND:  enter_error(lsf_pkg::ER_SVC_NF);
      lsf_pkg::EV_CHAR_NOT_FOUND: enter_error(lsf_pkg::ER_CHAR_NF);
      lsf_pkg::EV_PORT_FAILED:    enter_error(lsf_pkg::ER_PORT_FAILED);
      lsf_pkg::EV_NOTIFY_FAILED:  recover(lsf_pkg::ER_NTF_FAILED, 1'b1);
      lsf_pkg::EV_WRITE_FAILED:   recover(lsf_pkg::ER_WR_FAILED, 1'b1);
      lsf_pkg::EV_PORT_IO_FAILED: begin
        if (sess_st == lsf_pkg::ST_STREAMING) last_err = lsf_pkg::ER_PORT_IO;
        else enter_error(lsf_pkg::ER_PORT_IO);
      end
      lsf_pkg::EV_PORT_DEC_FAIL: begin
        if (sess_st == lsf_pkg::ST_STREAMING) last_err = lsf_pkg::ER_PORT_DEC;
        else enter_error(lsf_pkg::ER_PORT_DEC);
      end
      default: global_hit = 1'b0;
    endcase

    // State-specific events; anything else is an invalid transition
    if (!global_hit) begin
      ok = 1'b0;
      if (code == lsf_pkg::EV_DISCONNECTED && sess_st >= lsf_pkg::ST_WAIT_SVC &&
          sess_st <= lsf_pkg::ST_STREAMING) begin
        recover(lsf_pkg::ER_DISCONN, 1'b1);
        ok = 1'b1;
      end else begin
        case (sess_st)
          lsf_pkg::ST_IDLE: begin
            if (code == lsf_pkg::EV_SCAN) begin
              enter_state(lsf_pkg::ST_SCANNING);
              ok = 1'b1;
            end else if (code == lsf_pkg::EV_CONNECT) begin
              enter_state(lsf_pkg::ST_CONNECTING);
              ok = 1'b1;
            end
          end
          lsf_pkg::ST_SCANNING: begin
            if (code == lsf_pkg::EV_DEVICE_FOUND) begin
              ok = 1'b1;
            end else if (code == lsf_pkg::EV_CONNECT) begin
              enter_state(lsf_pkg::ST_CONNECTING);
              ok = 1'b1;
            end
          end
          lsf_pkg::ST_CONNECTING: begin
            if (code == lsf_pkg::EV_CONNECTED) begin
              link_up = 1'b1;
              enter_state(lsf_pkg::ST_WAIT_SVC);
              ok = 1'b1;
            end else if (code == lsf_pkg::EV_DISCONNECTED) begin
              recover(lsf_pkg::ER_CONN_FAILED, 1'b0);
              ok = 1'b1;
            end
          end
          lsf_pkg::ST_WAIT_SVC: begin
            if (code == lsf_pkg::EV_SVC_RESOLVED) begin
              svc_done = 1'b1;
              enter_state(lsf_pkg::ST_BINDING);
              ok = 1'b1;
            end
          end
          lsf_pkg::ST_BINDING: begin
            if (code == lsf_pkg::EV_CHAR_FOUND) begin
              enter_state(lsf_pkg::ST_CREATE_PORT);
              ok = 1'b1;
            end
          end
          lsf_pkg::ST_CREATE_PORT: begin
            if (code == lsf_pkg::EV_PORT_READY) begin
              port_rdy = 1'b1;
              enter_state(lsf_pkg::ST_ENABLE_NTF);
              ok = 1'b1;
            end
          end
          lsf_pkg::ST_ENABLE_NTF: begin
            if (code == lsf_pkg::EV_NOTIFY_OK) begin
              ntf_on = 1'b1;
              enter_state(lsf_pkg::ST_STREAMING);
              ok = 1'b1;
            end
          end
          lsf_pkg::ST_RECONNECTING: begin
            if (code == lsf_pkg::EV_RECONN_TIMER || code == lsf_pkg::EV_CONNECT) begin
              attempts = attempts + 16'd1;
              enter_state(lsf_pkg::ST_CONNECTING);
              ok = 1'b1;
            end
          end
          lsf_pkg::ST_ERROR: begin
            if (code == lsf_pkg::EV_CONNECT) begin
              drop_link(1'b0);
              enter_state(lsf_pkg::ST_CONNECTING);
              ok = 1'b1;
            end else if (code == lsf_pkg::EV_SCAN) begin
              drop_link(1'b0);
              enter_state(lsf_pkg::ST_SCANNING);
              ok = 1'b1;
            end
          end
          default: ;
        endcase
        if (!ok) last_err = lsf_pkg::ER_INVALID;
      end
    end

    rsp.accepted = ok;
    rsp.session_state = sess_st;
    rsp.error_code = last_err;
    rsp.streaming_ready = (sess_st == lsf_pkg::ST_STREAMING) && link_up && svc_done &&
                          ntf_on && port_rdy;
    rsp.attempt_count = attempts;
    return rsp;
  endfunction

  // Mostly push the session forward; mix in failures and raw noise
  function automatic logic [4:0] pick_event();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return 5'($urandom_range(31));
    if (roll < 30) begin
      case ($urandom_range(2))
        0:       return lsf_pkg::EV_TIMEOUT;
        1:       return lsf_pkg::EV_DISCONNECTED;
        default: return lsf_pkg::EV_CONNECT_FAILED;
      endcase
    end
    case (sess_st)
      lsf_pkg::ST_IDLE:
        return $urandom_range(1) ? lsf_pkg::EV_SCAN : lsf_pkg::EV_CONNECT;
      lsf_pkg::ST_SCANNING:
        return ($urandom_range(2) == 0) ? lsf_pkg::EV_DEVICE_FOUND : lsf_pkg::EV_CONNECT;
      lsf_pkg::ST_CONNECTING:   return lsf_pkg::EV_CONNECTED;
      lsf_pkg::ST_WAIT_SVC:     return lsf_pkg::EV_SVC_RESOLVED;
      lsf_pkg::ST_BINDING:      return lsf_pkg::EV_CHAR_FOUND;
      lsf_pkg::ST_CREATE_PORT:  return lsf_pkg::EV_PORT_READY;
      lsf_pkg::ST_ENABLE_NTF:   return lsf_pkg::EV_NOTIFY_OK;
      lsf_pkg::ST_STREAMING: begin
        case ($urandom_range(4))
          0:       return lsf_pkg::EV_PORT_IO_FAILED;
          1:       return lsf_pkg::EV_PORT_DEC_FAIL;
          2:       return lsf_pkg::EV_WRITE_FAILED;
          3:       return lsf_pkg::EV_NOTIFY_FAILED;
          default: return lsf_pkg::EV_DISCONNECTED;
        endcase
      end
      lsf_pkg::ST_RECONNECTING:
        return $urandom_range(1) ? lsf_pkg::EV_RECONN_TIMER : lsf_pkg::EV_CONNECT;
      lsf_pkg::ST_ERROR:
        return $urandom_range(1) ? lsf_pkg::EV_CONNECT : lsf_pkg::EV_SCAN;
      default:         return lsf_pkg::EV_FORGET;
    endcase
  endfunction

  // Hold the request until accepted, then record its expected result
  task automatic send_event(input logic [4:0] code, input logic typed,
                            input session_rsp_t typed_rsp);
    session_rsp_t model_rsp;
    ev_valid <= 1'b1;
    event_code <= code;
    @(posedge clk);
    while (ev_stall) @(posedge clk);
    model_rsp = predict_session(code);
    pending_results.push_back(typed ? typed_rsp : model_rsp);
  endtask

  // Unless quiet, sometimes drop valid for a random run of cycles
  task automatic idle_gap(input logic quiet);
    if (!quiet && ($urandom_range(99) < 28)) begin
      ev_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 28);
    end
  endtask

  // Drop valid and let every pending result come back
  task automatic drain();
    ev_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_auto_rc(input logic value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AUTO_RC_ADDR;
    pwdata <= {31'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    auto_rc = value;
  endtask

  // Stimulus: directed table, then random phases
  initial begin : stimulus
    int ph;
    int n;
    logic quiet;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < $size(DIR_ROWS); n++) begin
      idle_gap(1'b0);
      send_event(DIR_ROWS[n].code, DIR_ROWS[n].typed, DIR_ROWS[n].rsp);
    end

    for (ph = 0; ph < $size(PHASE_AUTO); ph++) begin
      drain();
      write_auto_rc(PHASE_AUTO[ph]);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        quiet = (ph == 2) && (n >= 40) && (n < 120);
        calm <= quiet;
        idle_gap(quiet);
        send_event(pick_event(), 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    fail_count += pending_results.size();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Check each accepted result against the oldest expectation; stall at random unless calm
  always @(posedge clk) begin : result_check
    session_rsp_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        report_fail($sformatf("result with no request pending: st %0d err %0d",
                              session_state, error_code));
      end else begin
        want = pending_results.pop_front();
        if (want.accepted !== accepted || want.session_state !== session_state ||
            want.error_code !== error_code || want.streaming_ready !== streaming_ready ||
            want.attempt_count !== attempt_count) begin
          report_fail($sformatf(
            "exp acc %0b st %0d err %0d rdy %0b att %0d / got %0b st %0d err %0d rdy %0b att %0d",
            want.accepted, want.session_state, want.error_code, want.streaming_ready,
            want.attempt_count, accepted, session_state, error_code, streaming_ready,
            attempt_count));
        end
      end
    end
    res_stall <= !calm && ($urandom_range(99) < 28);
  end

  // Watchdog: end the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((ev_valid && !ev_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
